// ===== hdl/wned_pkg.sv =====
package wned_pkg;

  localparam int unsigned HalfWindow   = 1024;
  localparam int unsigned LineLen      = 2 * HalfWindow;
  localparam int unsigned AddrBits     = $clog2(LineLen);
  localparam int unsigned SampleBits   = 16;
  localparam int unsigned SqBits       = 2 * SampleBits - 1;
  localparam int unsigned EnergyBits   = 42;
  localparam int unsigned RunBits      = 24;
  localparam int unsigned NoiseBits    = 55;
  localparam int unsigned MeanBits     = 31;
  localparam int unsigned RmsBits      = 16;
  localparam int unsigned CfgAddrBits  = 2;

  localparam logic [CfgAddrBits-1:0] RegThreshold  = 2'd0;
  localparam logic [CfgAddrBits-1:0] RegMinNoise   = 2'd1;
  localparam logic [CfgAddrBits-1:0] RegMinSilence = 2'd2;

  localparam logic [EnergyBits-1:0] ThresholdReset  = 42'd1387501568;
  localparam logic [RunBits-1:0]    MinNoiseReset   = 24'd48000;
  localparam logic [RunBits-1:0]    MinSilenceReset = 24'd24000;

  typedef enum logic [2:0] {
    StClear,
    StIdle,
    StRead,
    StUpdate,
    StDiv,
    StSqrt,
    StOut
  } state_e;

  // Event arithmetic unit states
  typedef enum logic [1:0] {EvIdle, EvDiv, EvSqrt, EvDone} ev_state_e;

  // Request to the event arithmetic unit and its answer
  typedef struct packed {
    logic                 start;
    logic [NoiseBits-1:0] energy;
    logic [RunBits-1:0]   count;
  } evt_req_t;

  typedef struct packed {
    logic                busy;
    logic                done;
    logic [MeanBits-1:0] mean;
    logic [RmsBits-1:0]  rms;
  } evt_rsp_t;

  function automatic logic [SqBits-1:0] square_of(input logic signed [SampleBits-1:0] v);
    logic [SampleBits-1:0] m;
    m = v[SampleBits-1] ? SampleBits'(-v) : v;
    return SqBits'({{SampleBits{1'b0}}, m} * {{SampleBits{1'b0}}, m});
  endfunction

endpackage

// ===== hdl/windowed_noise_event_detector_unit.sv =====
// Sliding-window energy detector. Each sample item enters a 2048-entry delay line
// held in block RAM; the window sum of squares judges the centre sample (written
// 1023 items earlier) as noise when it exceeds energy_threshold. An ordinary item
// passes through accept, RAM read, update and output register. An item that ends a
// noise run longer than min_noise_samples also runs the event unit: a 55-step
// restoring divide, a 16-step square root and a hand-over state. After reset the
// block clears the delay line, one entry a cycle, before it takes its first item;
// configuration writes are taken throughout.
module windowed_noise_event_detector_unit (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [wned_pkg::CfgAddrBits-1:0]       cfg_addr_i,
  input  logic [wned_pkg::EnergyBits-1:0]        cfg_wdata_i,
  input  logic                                   sample_valid_i,
  output logic                                   sample_ready_o,
  input  logic signed [wned_pkg::SampleBits-1:0] sample_i,
  output logic                                   result_valid_o,
  input  logic                                   result_ready_i,
  output logic                                   above_o,
  output logic signed [1:0]                      label_o,
  output logic                                   confirm_run_o,
  output logic [wned_pkg::RunBits-1:0]           run_length_o,
  output logic                                   event_valid_o,
  output logic [wned_pkg::RunBits-1:0]           event_duration_o,
  output logic [wned_pkg::MeanBits-1:0]          event_mean_power_o,
  output logic [wned_pkg::RmsBits-1:0]           event_rms_o
);

  localparam int unsigned AW = wned_pkg::AddrBits;
  localparam logic [wned_pkg::RunBits-1:0] RunMax = '1;
  localparam logic [wned_pkg::NoiseBits-1:0] NoiseMax = '1;

  // Configuration registers
  logic [wned_pkg::EnergyBits-1:0] thr_q;
  logic [wned_pkg::RunBits-1:0]    min_noise_q, min_sil_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q       <= wned_pkg::ThresholdReset;
      min_noise_q <= wned_pkg::MinNoiseReset;
      min_sil_q   <= wned_pkg::MinSilenceReset;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        wned_pkg::RegThreshold:  thr_q       <= cfg_wdata_i;
        wned_pkg::RegMinNoise:   min_noise_q <= cfg_wdata_i[wned_pkg::RunBits-1:0];
        wned_pkg::RegMinSilence: min_sil_q   <= cfg_wdata_i[wned_pkg::RunBits-1:0];
        default: ;
      endcase
    end
  end

  wned_pkg::state_e st_q, st_d;
  logic [AW:0]      clr_q, clr_d;
  logic [AW-1:0]    wp_q, wp_d;
  logic signed [wned_pkg::SampleBits-1:0] x_q, x_d;
  logic [wned_pkg::EnergyBits-1:0] we_q, we_d;
  logic             noise_q, noise_d, conf_q, conf_d;
  logic [wned_pkg::RunBits-1:0] cnt_q, cnt_d;
  logic [wned_pkg::NoiseBits-1:0] nen_q, nen_d;
  logic             above_q, above_d, cfm_q, cfm_d, ev_q, ev_d;
  logic signed [1:0] lab_q, lab_d;
  logic [wned_pkg::RunBits-1:0] dur_q, dur_d;
  logic [wned_pkg::MeanBits-1:0] mean_q, mean_d;
  logic [wned_pkg::RmsBits-1:0] rms_q, rms_d;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr, centre_addr;
  logic signed [wned_pkg::SampleBits-1:0] ram_wdata, old_s, centre_s, centre_v;
  logic [wned_pkg::EnergyBits-1:0] we_new;
  logic [wned_pkg::SqBits-1:0] csq;
  logic             above_c;
  logic [wned_pkg::RunBits-1:0] min_c;
  logic [wned_pkg::NoiseBits:0] nen_sum;
  wned_pkg::evt_req_t req;
  wned_pkg::evt_rsp_t rsp;

  // Centre entry is the one after wp + HALF_WINDOW; it equals the new sample only
  // when that address is being written now, which never happens for HALF_WINDOW > 1
  assign centre_addr = wp_q + AW'(wned_pkg::HalfWindow + 1);

  wned_line_ram u_ram (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (ram_waddr),
    .wdata_i   (ram_wdata),
    .raddr_a_i (wp_q),
    .raddr_b_i (centre_addr),
    .rdata_a_o (old_s),
    .rdata_b_o (centre_s)
  );

  wned_evt_unit u_evt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= wned_pkg::StClear;
      clr_q   <= '0;
      wp_q    <= '0;
      we_q    <= '0;
      noise_q <= 1'b0;
      conf_q  <= 1'b0;
      cnt_q   <= '0;
      nen_q   <= '0;
    end else begin
      st_q    <= st_d;
      clr_q   <= clr_d;
      wp_q    <= wp_d;
      we_q    <= we_d;
      noise_q <= noise_d;
      conf_q  <= conf_d;
      cnt_q   <= cnt_d;
      nen_q   <= nen_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q     <= x_d;
    above_q <= above_d;
    cfm_q   <= cfm_d;
    ev_q    <= ev_d;
    lab_q   <= lab_d;
    dur_q   <= dur_d;
    mean_q  <= mean_d;
    rms_q   <= rms_d;
  end

  assign centre_v = (centre_addr == wp_q) ? x_q : centre_s;
  assign we_new   = we_q + wned_pkg::EnergyBits'(wned_pkg::square_of(x_q))
                  - wned_pkg::EnergyBits'(wned_pkg::square_of(old_s));
  assign csq      = wned_pkg::square_of(centre_v);
  assign above_c  = we_new > thr_q;
  assign nen_sum  = {1'b0, nen_q} + (wned_pkg::NoiseBits + 1)'(csq);

  // Sequencer: clear, take item, read RAM, update state, run event, present
  always_comb begin
    st_d      = st_q;
    clr_d     = clr_q;
    wp_d      = wp_q;
    x_d       = x_q;
    we_d      = we_q;
    noise_d   = noise_q;
    conf_d    = conf_q;
    cnt_d     = cnt_q;
    nen_d     = nen_q;
    above_d   = above_q;
    cfm_d     = cfm_q;
    ev_d      = ev_q;
    lab_d     = lab_q;
    dur_d     = dur_q;
    mean_d    = mean_q;
    rms_d     = rms_q;
    ram_we    = 1'b0;
    ram_waddr = wp_q;
    ram_wdata = x_q;
    req       = '0;
    min_c     = '0;
    sample_ready_o = 1'b0;
    result_valid_o = 1'b0;
    case (st_q)
      wned_pkg::StClear: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q[AW-1:0];
        ram_wdata = '0;
        clr_d     = clr_q + 1'b1;
        if (clr_q[AW-1:0] == '1) st_d = wned_pkg::StIdle;
      end
      wned_pkg::StIdle: begin
        sample_ready_o = 1'b1;
        if (sample_valid_i) begin
          x_d  = sample_i;
          st_d = wned_pkg::StRead;
        end
      end
      wned_pkg::StRead: begin
        st_d = wned_pkg::StUpdate;
      end
      wned_pkg::StUpdate: begin
        ram_we  = 1'b1;
        wp_d    = wp_q + 1'b1;
        we_d    = we_new;
        above_d = above_c;
        ev_d    = 1'b0;
        dur_d   = '0;
        mean_d  = '0;
        rms_d   = '0;
        st_d    = wned_pkg::StOut;
        if (above_c != noise_q) begin
          if (noise_q && cnt_q > min_noise_q) begin
            ev_d      = 1'b1;
            dur_d     = cnt_q;
            req.start = 1'b1;
            req.energy = nen_q;
            req.count = cnt_q;
            st_d      = wned_pkg::StDiv;
          end
          noise_d = above_c;
          cnt_d   = wned_pkg::RunBits'(1);
          conf_d  = 1'b0;
          nen_d   = above_c ? wned_pkg::NoiseBits'(csq) : '0;
        end else begin
          if (cnt_q != RunMax) cnt_d = cnt_q + 1'b1;
          if (above_c) nen_d = nen_sum[wned_pkg::NoiseBits] ? NoiseMax
                                                            : nen_sum[wned_pkg::NoiseBits-1:0];
        end
        min_c = above_c ? min_noise_q : min_sil_q;
        cfm_d = 1'b0;
        if (!((above_c != noise_q) ? 1'b0 : conf_q) && cnt_d > min_c) begin
          conf_d = 1'b1;
          cfm_d  = 1'b1;
        end
        lab_d = conf_d ? (above_c ? 2'sd1 : -2'sd1) : 2'sd0;
      end
      wned_pkg::StDiv: begin
        st_d = wned_pkg::StSqrt;
      end
      wned_pkg::StSqrt: begin
        if (rsp.done) begin
          mean_d = rsp.mean;
          rms_d  = rsp.rms;
          st_d   = wned_pkg::StOut;
        end
      end
      wned_pkg::StOut: begin
        result_valid_o = 1'b1;
        if (result_ready_i) st_d = wned_pkg::StIdle;
      end
      default: st_d = wned_pkg::StIdle;
    endcase
  end

  assign above_o            = above_q;
  assign label_o            = lab_q;
  assign confirm_run_o      = cfm_q;
  assign run_length_o       = cnt_q;
  assign event_valid_o      = ev_q;
  assign event_duration_o   = dur_q;
  assign event_mean_power_o = mean_q;
  assign event_rms_o        = rms_q;

`ifndef SYNTHESIS
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sample_ready_o |-> !result_valid_o) else $error("ready during result");
  a_wp_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == wned_pkg::StUpdate |=> wp_q == $past(wp_q) + 1'b1) else $error("wp step");
  a_label_conf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (label_o != 2'sd0) == conf_q) else $error("label mismatch");
  a_event_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && event_valid_o) |-> !above_o) else $error("event while noisy");
`endif

endmodule

// ===== hdl/wned_line_ram.sv =====
module wned_line_ram (
  input  logic                                 clk_i,
  input  logic                                 we_i,
  input  logic [wned_pkg::AddrBits-1:0]        waddr_i,
  input  logic signed [wned_pkg::SampleBits-1:0] wdata_i,
  input  logic [wned_pkg::AddrBits-1:0]        raddr_a_i,
  input  logic [wned_pkg::AddrBits-1:0]        raddr_b_i,
  output logic signed [wned_pkg::SampleBits-1:0] rdata_a_o,
  output logic signed [wned_pkg::SampleBits-1:0] rdata_b_o
);

  logic signed [wned_pkg::SampleBits-1:0] mem [wned_pkg::LineLen];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Two registered read ports
  always_ff @(posedge clk_i) begin
    rdata_a_o <= mem[raddr_a_i];
    rdata_b_o <= mem[raddr_b_i];
  end

endmodule

// ===== hdl/wned_evt_unit.sv =====
module wned_evt_unit (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  wned_pkg::evt_req_t   req_i,
  output wned_pkg::evt_rsp_t   rsp_o
);

  localparam int unsigned DivSteps = wned_pkg::NoiseBits;
  localparam int unsigned DivCntW  = $clog2(DivSteps + 1);
  localparam int unsigned SvBits   = 2 * wned_pkg::RmsBits;
  localparam int unsigned SqSteps  = wned_pkg::RmsBits;
  localparam int unsigned RemW     = wned_pkg::RunBits + 1;

  wned_pkg::ev_state_e         st_q, st_d;
  logic [DivCntW-1:0]          cnt_q, cnt_d;
  logic [wned_pkg::NoiseBits-1:0] quo_q, quo_d;
  logic [RemW-1:0]             rem_q, rem_d;
  logic [wned_pkg::RunBits-1:0] den_q, den_d;
  logic [wned_pkg::MeanBits-1:0] mean_q, mean_d;
  logic [SvBits-1:0]           sv_q, sv_d;
  logic [SvBits+1:0]           srem_q, srem_d;
  logic [wned_pkg::RmsBits-1:0] root_q, root_d;
  logic [RemW-1:0]             rem_sh;
  logic [SvBits+1:0]           srem_sh, trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= wned_pkg::EvIdle;
    end else begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q  <= cnt_d;
    quo_q  <= quo_d;
    rem_q  <= rem_d;
    den_q  <= den_d;
    mean_q <= mean_d;
    sv_q   <= sv_d;
    srem_q <= srem_d;
    root_q <= root_d;
  end

  // Restoring divide one quotient bit a cycle, then digit-by-digit root
  always_comb begin
    st_d   = st_q;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    mean_d = mean_q;
    sv_d   = sv_q;
    srem_d = srem_q;
    root_d = root_q;
    rem_sh  = {rem_q[RemW-2:0], quo_q[wned_pkg::NoiseBits-1]};
    srem_sh = {srem_q[SvBits-1:0], sv_q[SvBits-1 -: 2]};
    trial   = {{(SvBits - wned_pkg::RmsBits){1'b0}}, root_q, 2'b01};
    case (st_q)
      wned_pkg::EvIdle: begin
        if (req_i.start) begin
          quo_d = req_i.energy;
          den_d = req_i.count;
          rem_d = '0;
          cnt_d = DivCntW'(DivSteps);
          st_d  = wned_pkg::EvDiv;
        end
      end
      wned_pkg::EvDiv: begin
        if (rem_sh >= {1'b0, den_q}) begin
          rem_d = rem_sh - {1'b0, den_q};
          quo_d = {quo_q[wned_pkg::NoiseBits-2:0], 1'b1};
        end else begin
          rem_d = rem_sh;
          quo_d = {quo_q[wned_pkg::NoiseBits-2:0], 1'b0};
        end
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == DivCntW'(1)) begin
          // the quotient stays below 2^32 even with a saturated run count
          mean_d = quo_d[wned_pkg::MeanBits-1:0];
          sv_d   = quo_d[SvBits-1:0];
          srem_d = '0;
          root_d = '0;
          cnt_d  = DivCntW'(SqSteps);
          st_d   = wned_pkg::EvSqrt;
        end
      end
      wned_pkg::EvSqrt: begin
        sv_d = {sv_q[SvBits-3:0], 2'b00};
        if (srem_sh >= trial) begin
          srem_d = srem_sh - trial;
          root_d = {root_q[wned_pkg::RmsBits-2:0], 1'b1};
        end else begin
          srem_d = srem_sh;
          root_d = {root_q[wned_pkg::RmsBits-2:0], 1'b0};
        end
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == DivCntW'(1)) begin
          st_d = wned_pkg::EvDone;
        end
      end
      wned_pkg::EvDone: begin
        st_d = wned_pkg::EvIdle;
      end
      default: st_d = wned_pkg::EvIdle;
    endcase
  end

  assign rsp_o.busy = (st_q != wned_pkg::EvIdle);
  assign rsp_o.done = (st_q == wned_pkg::EvDone);
  assign rsp_o.mean = mean_q;
  assign rsp_o.rms  = root_q;

`ifndef SYNTHESIS
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> st_q == wned_pkg::EvIdle) else $error("event unit started while busy");
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.done |=> !rsp_o.done) else $error("done held");
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |=> rsp_o.busy) else $error("start not taken");
`endif

endmodule
